FILE: hdl/clp_pkg.sv
// shared types and constants of the context load profiler
package clp_pkg;

    localparam int CONTEXTS_DEF = 7;
    localparam logic [31:0] WINDOW_RESET = 32'd80000000;
    localparam logic [3:0] IRQ_LIMIT_RESET = 4'd4;
    localparam logic [13:0] FULL_SCALE = 14'd10000;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_END = 2'd1;
    localparam logic [1:0] KIND_SERVICE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] OUT_TOKEN = 2'd0;
    localparam logic [1:0] OUT_END = 2'd1;
    localparam logic [1:0] OUT_REPORT = 2'd2;
    localparam logic [1:0] OUT_TOTAL = 2'd3;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_AVAIL = 2'd1;
    localparam logic [1:0] REG_IRQ_LIMIT = 2'd2;

    localparam logic [2:0] ST_UNAVAIL = 3'b001;
    localparam logic [2:0] ST_PREEMPT = 3'b010;
    localparam logic [2:0] ST_TOTAL = 3'b100;

    // item as classified by the front end
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  context_index;
        logic [31:0] now_cycles;
        logic [31:0] token_start;
        logic [31:0] token_interrupt;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [3:0]  report_context;
        logic [31:0] cycles_a;
        logic [31:0] cycles_b;
        logic [13:0] load_hundredths;
        logic [13:0] reserve_hundredths;
        logic [2:0]  status_flags;
        logic        last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_SUM,
        BK_START,
        BK_DIV,
        BK_REPORT,
        BK_TOTAL,
        BK_WAIT
    } back_state_t;

endpackage

FILE: hdl/context_load_profiler_unit.sv
// per-context load profiler: front end, item queue, back end
// a begin/end item passes the front-end hold register, the queue and the back-end item register;
// its result is formed in the exec state and made valid in the wait state, when the output is free
// the back end serves one item at a time; due service: summing pass, shared divider per context
// reset: rst_n clears the counters, totals, state and control registers to their defaults at once
module context_load_profiler_unit #(
    parameter int CONTEXTS = clp_pkg::CONTEXTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // kind
    input  logic [103:0] s_axis_tdata,   // context_index, now_cycles, token_start, token_interrupt, pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [1:0]   m_axis_tuser,   // out_kind
    output logic         m_axis_tlast,
    output logic [103:0] m_axis_tdata,   // report_context, cycles_a, cycles_b, load, reserve, status, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [31:0] window_reg;
    logic        avail_reg;
    logic [3:0]  irq_limit_reg;

    clp_pkg::item_t   in_item, q_in, q_head;
    clp_pkg::result_t res;
    logic q_push, q_full, q_pop, q_empty;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= clp_pkg::WINDOW_RESET;
            avail_reg <= 1'b1;
            irq_limit_reg <= clp_pkg::IRQ_LIMIT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                clp_pkg::REG_WINDOW: window_reg <= pwdata;
                clp_pkg::REG_AVAIL: avail_reg <= pwdata[0];
                clp_pkg::REG_IRQ_LIMIT: irq_limit_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            clp_pkg::REG_WINDOW: prdata = window_reg;
            clp_pkg::REG_AVAIL: prdata = {31'd0, avail_reg};
            clp_pkg::REG_IRQ_LIMIT: prdata = {28'd0, irq_limit_reg};
            default: prdata = '0;
        endcase
    end

    assign in_item.kind = s_axis_tuser;
    assign in_item.context_index = s_axis_tdata[3:0];
    assign in_item.now_cycles = s_axis_tdata[35:4];
    assign in_item.token_start = s_axis_tdata[67:36];
    assign in_item.token_interrupt = s_axis_tdata[99:68];

    clp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_push(q_push), .q_item(q_in), .q_full(q_full)
    );

    clp_queue #(.DEPTH(2)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_item(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(q_head)
    );

    clp_back #(.CONTEXTS(CONTEXTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
        .window_period(window_reg), .counter_available(avail_reg),
        .irq_limit(irq_limit_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_result(res)
    );

    assign m_axis_tuser = res.out_kind;
    assign m_axis_tlast = res.last_of_run;
    assign m_axis_tdata = {5'd0, res.status_flags, res.reserve_hundredths,
                           res.load_hundredths, res.cycles_b, res.cycles_a,
                           res.report_context};
endmodule

FILE: hdl/clp_queue.sv
// short queue between the front end and the back end
module clp_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clp_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output clp_pkg::item_t  head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    clp_pkg::item_t    mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next;
    logic [AW-1:0]     rd_reg, rd_next;
    logic [AW:0]       cnt_reg, cnt_next;

    assign full = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        cnt_next = cnt_reg;
        if (push && !full)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end
endmodule

FILE: hdl/clp_divider.sv
// restoring divider: floor(busy*10000/window), two quotient bits a cycle
module clp_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] busy,
    input  logic [31:0] window,
    output logic        done,
    output logic [13:0] quotient
);
    // quotient stays below 10000 whenever busy < window, so 14 bits suffice
    logic [45:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [13:0] q_reg, q_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] r1, r2;
    logic        b1, b2;

    assign done = done_reg;
    assign quotient = q_reg;

    always_comb
    begin
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        r1 = {rem_reg[31:0], num_reg[45]};
        b1 = (r1 >= {1'b0, den_reg});
        if (b1)
        begin
            r1 = r1 - {1'b0, den_reg};
        end
        r2 = {r1[31:0], num_reg[44]};
        b2 = (r2 >= {1'b0, den_reg});
        if (b2)
        begin
            r2 = r2 - {1'b0, den_reg};
        end
        if (run_reg)
        begin
            rem_next = r2;
            num_next = {num_reg[43:0], 2'b00};
            if (cnt_reg < 3'd7)
            begin
                q_next = {q_reg[11:0], b1, b2};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 3'd7)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    logic [45:0] prod;
    assign prod = 46'(busy) * 46'(14'd10000);

    // the top 32 numerator bits are less than window, so start with them as remainder
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, prod[45:14]};
            num_reg <= {prod[13:0], 32'd0};
            den_reg <= window;
            q_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            q_reg <= q_next;
        end
    end
endmodule

FILE: hdl/clp_front.sv
// front end: takes input transfers, drops unused kinds, queues the rest
module clp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  clp_pkg::item_t  in_item,
    output logic            q_push,
    output clp_pkg::item_t  q_item,
    input  logic            q_full
);
    logic           hold_reg, hold_next;
    clp_pkg::item_t item_reg;

    assign in_ready = !hold_reg || !q_full;
    assign q_push = hold_reg;
    assign q_item = item_reg;

    always_comb
    begin
        hold_next = hold_reg;
        if (hold_reg && !q_full)
        begin
            hold_next = 1'b0;
        end
        // kind three causes nothing and is not kept
        if (in_valid && in_ready && (in_item.kind != clp_pkg::KIND_UNUSED))
        begin
            hold_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end
endmodule

FILE: hdl/clp_back.sv
// back end: state update, window reports through the shared divider
module clp_back #(
    parameter int CONTEXTS = clp_pkg::CONTEXTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  clp_pkg::item_t   q_head,
    output logic             q_pop,
    input  logic [31:0]      window_period,
    input  logic             counter_available,
    input  logic [3:0]       irq_limit,
    output logic             out_valid,
    input  logic             out_ready,
    output clp_pkg::result_t out_result
);
    localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

    clp_pkg::back_state_t state_reg, state_next;

    logic [31:0] busy_reg [CONTEXTS];
    logic [31:0] last_reg [CONTEXTS];
    logic [31:0] max_reg [CONTEXTS];
    logic [31:0] irq_total_reg;
    logic [31:0] win_start_reg;
    logic [31:0] seq_reg;
    logic [2:0]  sticky_reg;

    clp_pkg::item_t   cur_reg;
    logic [CW-1:0]    idx_reg;
    logic [31:0]      measured_reg;
    logic [32:0]      sum_cyc_reg;
    logic             bad_reg;
    logic [17:0]      sum_load_reg;
    clp_pkg::result_t res_reg;
    logic             res_valid_reg;

    logic        div_start, div_done;
    logic [13:0] div_q;
    logic [31:0] period, measured, raw, pre, excl, cur_busy;
    logic        ctx_ok, due, emit, pre_bad, tot_bad;
    logic [13:0] load;
    logic [2:0]  sticky_exec;
    logic [32:0] sum_step;

    clp_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .busy(cur_busy), .window(measured_reg),
        .done(div_done), .quotient(div_q)
    );

    assign out_valid = res_valid_reg;
    assign out_result = res_reg;
    assign cur_busy = busy_reg[idx_reg];

    always_comb
    begin
        period = (window_period == '0) ? 32'd1 : window_period;
        measured = cur_reg.now_cycles - win_start_reg;
        due = (measured >= period);
        ctx_ok = ({1'b0, cur_reg.context_index} < 5'(CONTEXTS));
        raw = cur_reg.now_cycles - cur_reg.token_start;
        pre = irq_total_reg - cur_reg.token_interrupt;
        excl = (pre > raw) ? 32'd0 : raw - pre;
        sticky_exec = sticky_reg;
        if (!counter_available)
        begin
            sticky_exec = sticky_reg | clp_pkg::ST_UNAVAIL;
        end
        else if (cur_reg.kind == clp_pkg::KIND_END && ctx_ok && pre > raw)
        begin
            sticky_exec = sticky_reg | clp_pkg::ST_PREEMPT;
        end
        load = (cur_busy >= measured_reg) ? clp_pkg::FULL_SCALE : div_q;
        sum_step = sum_cyc_reg + {1'b0, cur_busy};
        // with no overflow and the cycle sum inside the window the load sum stays in range
        pre_bad = bad_reg || (sum_cyc_reg[31:0] > measured_reg);
        tot_bad = pre_bad || (sum_load_reg > 18'(clp_pkg::FULL_SCALE));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clp_pkg::BK_IDLE:
                if (!q_empty && (!res_valid_reg || out_ready)) state_next = clp_pkg::BK_EXEC;
            clp_pkg::BK_EXEC:
                if (counter_available && cur_reg.kind == clp_pkg::KIND_SERVICE)
                    state_next = due ? clp_pkg::BK_SUM : clp_pkg::BK_IDLE;
                else
                    state_next = clp_pkg::BK_WAIT;
            clp_pkg::BK_SUM:
                if (idx_reg == CW'(CONTEXTS - 1)) state_next = clp_pkg::BK_START;
            clp_pkg::BK_START:
                state_next = clp_pkg::BK_DIV;
            clp_pkg::BK_DIV:
                if (div_done) state_next = clp_pkg::BK_REPORT;
            clp_pkg::BK_REPORT:
                if (!res_valid_reg || out_ready)
                    state_next = (idx_reg == CW'(CONTEXTS - 1)) ?
                                 clp_pkg::BK_TOTAL : clp_pkg::BK_START;
            clp_pkg::BK_TOTAL:
                if (!res_valid_reg || out_ready) state_next = clp_pkg::BK_IDLE;
            clp_pkg::BK_WAIT:
                if (!res_valid_reg || out_ready) state_next = clp_pkg::BK_IDLE;
            default: state_next = clp_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop = (state_reg == clp_pkg::BK_IDLE) && !q_empty && (!res_valid_reg || out_ready);
        div_start = (state_reg == clp_pkg::BK_START);
        emit = ((state_reg == clp_pkg::BK_REPORT) || (state_reg == clp_pkg::BK_TOTAL) ||
                (state_reg == clp_pkg::BK_WAIT)) && (!res_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clp_pkg::BK_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < CONTEXTS; i++)
            begin
                busy_reg[i] <= '0;
                last_reg[i] <= '0;
                max_reg[i] <= '0;
            end
            irq_total_reg <= '0;
            win_start_reg <= '0;
            seq_reg <= '0;
            sticky_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                clp_pkg::BK_EXEC:
                begin
                    sticky_reg <= sticky_exec;
                    idx_reg <= '0;
                    if (counter_available && cur_reg.kind == clp_pkg::KIND_SERVICE && due)
                    begin
                        win_start_reg <= cur_reg.now_cycles;
                    end
                    if (counter_available && cur_reg.kind == clp_pkg::KIND_END && ctx_ok)
                    begin
                        busy_reg[cur_reg.context_index[CW-1:0]] <=
                            busy_reg[cur_reg.context_index[CW-1:0]] + excl;
                        last_reg[cur_reg.context_index[CW-1:0]] <= raw;
                        if (raw > max_reg[cur_reg.context_index[CW-1:0]])
                        begin
                            max_reg[cur_reg.context_index[CW-1:0]] <= raw;
                        end
                        if (cur_reg.context_index <= irq_limit)
                        begin
                            irq_total_reg <= irq_total_reg + excl;
                        end
                    end
                end
                clp_pkg::BK_SUM:
                    idx_reg <= (idx_reg == CW'(CONTEXTS - 1)) ? '0 : idx_reg + 1'b1;
                clp_pkg::BK_REPORT:
                    if (emit)
                    begin
                        busy_reg[idx_reg] <= '0;
                        if (idx_reg != CW'(CONTEXTS - 1))
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                clp_pkg::BK_TOTAL:
                    if (emit)
                    begin
                        seq_reg <= seq_reg + 1'b1;
                        if (tot_bad)
                        begin
                            sticky_reg <= sticky_reg | clp_pkg::ST_TOTAL;
                        end
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        clp_pkg::result_t r;
        r = '0;
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (state_reg == clp_pkg::BK_EXEC)
        begin
            measured_reg <= measured;
            sum_cyc_reg <= '0;
            bad_reg <= 1'b0;
            sum_load_reg <= '0;
            r.status_flags = sticky_exec;
            r.last_of_run = 1'b1;
            if (!counter_available)
            begin
                r.out_kind = (cur_reg.kind == clp_pkg::KIND_SERVICE) ?
                             clp_pkg::OUT_TOTAL : cur_reg.kind;
            end
            else if (cur_reg.kind == clp_pkg::KIND_BEGIN)
            begin
                r.out_kind = clp_pkg::OUT_TOKEN;
                r.cycles_a = cur_reg.now_cycles;
                r.cycles_b = irq_total_reg;
            end
            else
            begin
                r.out_kind = clp_pkg::OUT_END;
                r.cycles_a = ctx_ok ? raw : 32'd0;
            end
            res_reg <= r;
        end
        else if (state_reg == clp_pkg::BK_SUM)
        begin
            if (!bad_reg)
            begin
                if (sum_step[32])
                begin
                    bad_reg <= 1'b1;
                    sum_cyc_reg <= 33'h0FFFFFFFF;
                end
                else
                begin
                    sum_cyc_reg <= sum_step;
                end
            end
        end
        else if (state_reg == clp_pkg::BK_REPORT && emit)
        begin
            r.out_kind = clp_pkg::OUT_REPORT;
            r.report_context = 4'(idx_reg);
            r.cycles_a = last_reg[idx_reg];
            r.cycles_b = max_reg[idx_reg];
            r.load_hundredths = load;
            r.status_flags = pre_bad ? (sticky_reg | clp_pkg::ST_TOTAL) : sticky_reg;
            r.last_of_run = 1'b0;
            res_reg <= r;
            sum_load_reg <= sum_load_reg + 18'(load);
        end
        else if (state_reg == clp_pkg::BK_TOTAL && emit)
        begin
            r.out_kind = clp_pkg::OUT_TOTAL;
            r.cycles_a = measured_reg;
            r.cycles_b = seq_reg + 1'b1;
            r.load_hundredths = tot_bad ? clp_pkg::FULL_SCALE : sum_load_reg[13:0];
            r.reserve_hundredths = tot_bad ? 14'd0 :
                                   clp_pkg::FULL_SCALE - sum_load_reg[13:0];
            r.status_flags = tot_bad ? (sticky_reg | clp_pkg::ST_TOTAL) : sticky_reg;
            r.last_of_run = 1'b1;
            res_reg <= r;
        end
    end
endmodule

FILE: bench/clp_checker.sv
// checker for the context load profiler: mirrors the registers, predicts and compares results
module clp_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,
    input  logic [103:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast,
    input  logic [103:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           outstanding,
    output logic [31:0]  irq_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCTX = clp_pkg::CONTEXTS_DEF;

    logic [31:0] period_reg;
    logic        avail_reg;
    logic [3:0]  irq_limit_reg;

    logic [31:0] busy_acc [NCTX];
    logic [31:0] last_raw_c [NCTX];
    logic [31:0] max_raw_c [NCTX];
    logic [31:0] irq_busy;
    logic [31:0] window_origin;
    logic [31:0] seq_no;
    logic [2:0]  sticky;
    int          fails = 0;

    clp_pkg::result_t expected_q[$];

    assign outstanding = expected_q.size();
    assign irq_total = irq_busy;
    assign fail_count = fails;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    function automatic logic [13:0] load_of(input logic [31:0] busy, input logic [31:0] span);
        logic [63:0] prod;
        if (busy >= span)
            return clp_pkg::FULL_SCALE;
        prod = 64'(busy) * 64'd10000;
        return 14'(prod / 64'(span));
    endfunction

    task automatic push_result(input logic [1:0] k, input logic [3:0] c, input logic [31:0] a,
                               input logic [31:0] b, input logic [13:0] ld,
                               input logic [13:0] rs);
        clp_pkg::result_t r;
        r.out_kind = k;
        r.report_context = c;
        r.cycles_a = a;
        r.cycles_b = b;
        r.load_hundredths = ld;
        r.reserve_hundredths = rs;
        r.status_flags = 3'b000;
        r.last_of_run = 1'b0;
        expected_q.push_back(r);
    endtask

    // works out the results of one accepted item and advances the mirrored state
    task automatic predict_results(input logic [1:0] kind, input clp_pkg::item_t it);
        int first;
        logic [31:0] raw, pre, excl, span, per, sum_cyc, sum_load;
        logic [13:0] ld;
        logic bad;
        first = expected_q.size();
        if (kind == clp_pkg::KIND_UNUSED)
            return;
        if (!avail_reg) begin
            sticky |= clp_pkg::ST_UNAVAIL;
            push_result(kind == clp_pkg::KIND_SERVICE ? clp_pkg::OUT_TOTAL : kind, 4'd0,
                        32'd0, 32'd0, 14'd0, 14'd0);
        end else if (kind == clp_pkg::KIND_BEGIN) begin
            push_result(clp_pkg::OUT_TOKEN, 4'd0, it.now_cycles, irq_busy, 14'd0, 14'd0);
        end else if (kind == clp_pkg::KIND_END) begin
            raw = '0;
            if (it.context_index < NCTX) begin
                raw = it.now_cycles - it.token_start;
                pre = irq_busy - it.token_interrupt;
                if (pre > raw) begin
                    excl = '0;
                    sticky |= clp_pkg::ST_PREEMPT;
                end else begin
                    excl = raw - pre;
                end
                busy_acc[it.context_index] += excl;
                last_raw_c[it.context_index] = raw;
                if (raw > max_raw_c[it.context_index])
                    max_raw_c[it.context_index] = raw;
                if (it.context_index <= irq_limit_reg)
                    irq_busy += excl;
            end
            push_result(clp_pkg::OUT_END, 4'd0, raw, 32'd0, 14'd0, 14'd0);
        end else begin
            per = (period_reg == '0) ? 32'd1 : period_reg;
            span = it.now_cycles - window_origin;
            if (span < per)
                return;
            window_origin = it.now_cycles;
            sum_cyc = '0;
            sum_load = '0;
            bad = 1'b0;
            for (int i = 0; i < NCTX; i++) begin
                ld = load_of(busy_acc[i], span);
                push_result(clp_pkg::OUT_REPORT, 4'(i), last_raw_c[i], max_raw_c[i], ld, 14'd0);
                sum_load += 32'(ld);
                if (!bad) begin
                    if (32'hFFFF_FFFF - sum_cyc < busy_acc[i]) begin
                        sum_cyc = 32'hFFFF_FFFF;
                        bad = 1'b1;
                    end else begin
                        sum_cyc += busy_acc[i];
                    end
                end
                busy_acc[i] = '0;
            end
            if (bad || sum_cyc > span || sum_load > 32'(clp_pkg::FULL_SCALE)) begin
                sum_load = 32'(clp_pkg::FULL_SCALE);
                sticky |= clp_pkg::ST_TOTAL;
            end
            seq_no++;
            push_result(clp_pkg::OUT_TOTAL, 4'd0, span, seq_no, 14'(sum_load),
                        14'(32'(clp_pkg::FULL_SCALE) - sum_load));
        end
        for (int k = first; k < expected_q.size(); k++)
            expected_q[k].status_flags = sticky;
        expected_q[expected_q.size() - 1].last_of_run = 1'b1;
    endtask

    task automatic check_result();
        clp_pkg::result_t got, want;
        got.out_kind = m_axis_tuser;
        got.report_context = m_axis_tdata[3:0];
        got.cycles_a = m_axis_tdata[35:4];
        got.cycles_b = m_axis_tdata[67:36];
        got.load_hundredths = m_axis_tdata[81:68];
        got.reserve_hundredths = m_axis_tdata[95:82];
        got.status_flags = m_axis_tdata[98:96];
        got.last_of_run = m_axis_tlast;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected result kind", 32'(got.out_kind), 32'd0);
            return;
        end
        want = expected_q.pop_front();
        if (got.out_kind !== want.out_kind)
            report_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
        if (got.report_context !== want.report_context)
            report_mismatch("report_context", 32'(got.report_context), 32'(want.report_context));
        if (got.cycles_a !== want.cycles_a)
            report_mismatch("cycles_a", got.cycles_a, want.cycles_a);
        if (got.cycles_b !== want.cycles_b)
            report_mismatch("cycles_b", got.cycles_b, want.cycles_b);
        if (got.load_hundredths !== want.load_hundredths)
            report_mismatch("load", 32'(got.load_hundredths), 32'(want.load_hundredths));
        if (got.reserve_hundredths !== want.reserve_hundredths)
            report_mismatch("reserve", 32'(got.reserve_hundredths),
                            32'(want.reserve_hundredths));
        if (got.status_flags !== want.status_flags)
            report_mismatch("status", 32'(got.status_flags), 32'(want.status_flags));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch("last", 32'(got.last_of_run), 32'(want.last_of_run));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clp_pkg::item_t it;
        if (!rst_n) begin
            period_reg <= clp_pkg::WINDOW_RESET;
            avail_reg <= 1'b1;
            irq_limit_reg <= clp_pkg::IRQ_LIMIT_RESET;
            for (int i = 0; i < NCTX; i++)
            begin
                busy_acc[i] = '0;
                last_raw_c[i] = '0;
                max_raw_c[i] = '0;
            end
            irq_busy = '0;
            window_origin = '0;
            seq_no = '0;
            sticky = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready) begin
                it.kind = s_axis_tuser;
                it.context_index = s_axis_tdata[3:0];
                it.now_cycles = s_axis_tdata[35:4];
                it.token_start = s_axis_tdata[67:36];
                it.token_interrupt = s_axis_tdata[99:68];
                predict_results(s_axis_tuser, it);
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    clp_pkg::REG_WINDOW:    period_reg <= pwdata;
                    clp_pkg::REG_AVAIL:     avail_reg <= pwdata[0];
                    clp_pkg::REG_IRQ_LIMIT: irq_limit_reg <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: bench/tb_top.sv
// top of the context load profiler bench: clock, reset, stimulus, receiver and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [1:0]   s_axis_tuser;   // kind
    logic [103:0] s_axis_tdata;   // context_index, now_cycles, token_start, token_interrupt
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [1:0]   m_axis_tuser;   // out_kind
    logic         m_axis_tlast;
    logic [103:0] m_axis_tdata;   // report_context, cycles_a, cycles_b, load, reserve, status
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int          fail_count;
    int          outstanding;
    logic [31:0] irq_total;

    logic        hold_req;
    logic        quiet;
    int          idle_cycles = 0;
    logic [31:0] tnow;
    logic [31:0] open_start[$];
    logic [31:0] open_irq[$];

    context_load_profiler_unit u_dut (.*);

    clp_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        if (quiet)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int stall_left;
        logic hold_done;
        stall_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [3:0] ctx,
                             input logic [31:0] now, input logic [31:0] tstart,
                             input logic [31:0] tirq);
        logic [103:0] word;
        logic rdy;
        word = {4'd0, tirq, tstart, now, ctx};
        s_axis_tuser <= kind;
        s_axis_tdata <= word;
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = s_axis_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // drain, then let a possibly silent service item finish before touching registers
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [3:0] ctx;
        if ($urandom_range(0, 29) == 0)
            tnow = $urandom();
        else
            tnow = tnow + $urandom_range(1, 3000);
        r = $urandom_range(0, 99);
        ctx = 4'($urandom_range(0, clp_pkg::CONTEXTS_DEF - 1));
        if ($urandom_range(0, 9) == 0)
            ctx = 4'($urandom_range(0, 15));
        if (r < 38) begin
            open_start.push_back(tnow);
            open_irq.push_back(irq_total);
            send_item(clp_pkg::KIND_BEGIN, 4'($urandom()), tnow, $urandom(), $urandom());
        end else if (r < 78) begin
            if (open_start.size() > 0 && $urandom_range(0, 9) < 9)
                send_item(clp_pkg::KIND_END, ctx, tnow, open_start.pop_back(),
                          open_irq.pop_back());
            else
                send_item(clp_pkg::KIND_END, ctx, tnow, $urandom(), $urandom());
        end else if (r < 95) begin
            send_item(clp_pkg::KIND_SERVICE, 4'($urandom()), tnow, $urandom(), $urandom());
        end else begin
            send_item(clp_pkg::KIND_UNUSED, 4'($urandom()), $urandom(), $urandom(),
                      $urandom());
        end
        idle_gap();
    endtask

    initial
    begin
        logic [31:0] periods[7];
        logic        avails[7];
        logic [3:0]  limits[7];
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        quiet = 1'b0;
        tnow = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register defaults
        send_item(clp_pkg::KIND_BEGIN, 4'd0, 32'd0, 32'd0, 32'd0);
        send_item(clp_pkg::KIND_END, 4'd0, 32'd100, 32'd0, 32'd0);
        send_item(clp_pkg::KIND_END, 4'd6, 32'hFFFF_FFFF, 32'd0, irq_total);
        send_item(clp_pkg::KIND_END, 4'd7, 32'd5, 32'd1, 32'd0);
        send_item(clp_pkg::KIND_END, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // preempted cycles larger than raw
        send_item(clp_pkg::KIND_END, 4'd1, 32'd10, 32'd5, 32'd0);
        send_item(clp_pkg::KIND_UNUSED, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // window not yet due, then due over the widest span
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'd1000, 32'd0, 32'd0);
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        drain_results();
        reg_write(clp_pkg::REG_WINDOW, 32'd0);
        reg_write(clp_pkg::REG_IRQ_LIMIT, 32'd15);
        // zero period acts as one cycle
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'd0, 32'd0, 32'd0);
        drain_results();
        // summed cycles overflow 32 bits
        send_item(clp_pkg::KIND_END, 4'd2, 32'hFFFF_FFFF, 32'd0, irq_total);
        drain_results();
        send_item(clp_pkg::KIND_END, 4'd3, 32'hFFFF_FFFF, 32'd0, irq_total);
        send_item(clp_pkg::KIND_END, 4'd4, 32'h8000_0000, 32'd0, 32'd0);
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'd2, 32'd0, 32'd0);
        drain_results();
        reg_write(clp_pkg::REG_WINDOW, 32'hFFFF_FFFF);
        reg_write(clp_pkg::REG_AVAIL, 32'd0);
        // counter unavailable
        send_item(clp_pkg::KIND_BEGIN, 4'd3, 32'd77, 32'd1, 32'd1);
        send_item(clp_pkg::KIND_END, 4'd2, 32'd99, 32'd1, 32'd1);
        send_item(clp_pkg::KIND_SERVICE, 4'd0, 32'd1, 32'd1, 32'd1);
        send_item(clp_pkg::KIND_UNUSED, 4'd0, 32'd1, 32'd1, 32'd1);
        drain_results();

        periods = '{32'd20000, 32'd5000, 32'd1, 32'd0, 32'd100000, 32'hFFFF_FFFF,
                    clp_pkg::WINDOW_RESET};
        avails = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        limits = '{4'd4, 4'd15, 4'd0, 4'd6, 4'd3, 4'd7, 4'd4};
        for (int p = 0; p < 7; p++)
        begin
            reg_write(clp_pkg::REG_WINDOW, periods[p]);
            reg_write(clp_pkg::REG_AVAIL, 32'(avails[p]));
            reg_write(clp_pkg::REG_IRQ_LIMIT, 32'(limits[p]));
            quiet = (p == 2);
            open_start.delete();
            open_irq.delete();
            for (int n = 0; n < 70; n++)
            begin
                if (p == 1 && n == 10)
                    hold_req = 1'b1;
                random_item();
            end
            drain_results();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
